// ===== rtl/assert_macros.svh =====
// Assertion macros used by tsg_checker.
// Depends on nothing; each macro expects clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");

`endif

// ===== rtl/tsg_pkg.sv =====
// Shared constants for the trajectory setpoint generator.
// Used by the multiplier, the waypoint memory and the top level; depends on nothing.
package tsg_pkg;

    localparam int MUL_W   = 32;
    localparam int POINT_W = 16;
    localparam int PTIME_W = 32;
    localparam int TIME_W  = 48;
    localparam int PHASE_W = 40;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_AMP   = 3'd1;
    localparam logic [2:0] REG_VAMP  = 3'd2;
    localparam logic [2:0] REG_PSTEP = 3'd3;
    localparam logic [2:0] REG_PCNT  = 3'd4;

    // trajectory modes
    localparam logic [2:0] MODE_XSINE  = 3'd0;
    localparam logic [2:0] MODE_YSINE  = 3'd1;
    localparam logic [2:0] MODE_CIRCLE = 3'd2;
    localparam logic [2:0] MODE_WAYPT  = 3'd3;

    // register reset values
    localparam logic [2:0]  RST_MODE  = 3'd4;
    localparam logic [14:0] RST_AMP   = 15'd2048;
    localparam logic [14:0] RST_VAMP  = 15'd2573;
    localparam logic [23:0] RST_PSTEP = 24'd219902;
    localparam logic [6:0]  RST_PCNT  = 7'd50;

    // sine series coefficients, Q30 scaled
    localparam logic [30:0] C1 = 31'd1686629714;
    localparam logic [30:0] C3 = 31'd693598667;
    localparam logic [30:0] C5 = 31'd85569306;
    localparam logic [30:0] C7 = 31'd5026995;
    localparam logic [30:0] C9 = 31'd172272;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [63:0] HALF_Q30 = 64'h2000_0000;

endpackage

// ===== rtl/tsg_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on tsg_pkg for the operand width.
module tsg_mul
(
    input  logic                            clk,
    input  logic [tsg_pkg::MUL_W-1:0]       a,
    input  logic [tsg_pkg::MUL_W-1:0]       b,
    output logic [2*tsg_pkg::MUL_W-1:0]     p
);

    logic [2*tsg_pkg::MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= (2*tsg_pkg::MUL_W)'(a) * (2*tsg_pkg::MUL_W)'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/tsg_wp_mem.sv =====
// Waypoint store: x, y and start time per entry, one write and one read port.
// Depends on tsg_pkg for the field widths; read data is registered.
module tsg_wp_mem
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic                               clk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [tsg_pkg::POINT_W-1:0] wx,
    input  logic signed [tsg_pkg::POINT_W-1:0] wy,
    input  logic [tsg_pkg::PTIME_W-1:0]        wt,
    input  logic [AW-1:0]                      raddr,
    output logic signed [tsg_pkg::POINT_W-1:0] rx,
    output logic signed [tsg_pkg::POINT_W-1:0] ry,
    output logic [tsg_pkg::PTIME_W-1:0]        rt
);

    logic signed [tsg_pkg::POINT_W-1:0] x_mem [DEPTH];
    logic signed [tsg_pkg::POINT_W-1:0] y_mem [DEPTH];
    logic [tsg_pkg::PTIME_W-1:0]        t_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            x_mem[waddr] <= wx;
            y_mem[waddr] <= wy;
            t_mem[waddr] <= wt;
        end
        rx <= x_mem[raddr];
        ry <= y_mem[raddr];
        rt <= t_mem[raddr];
    end

endmodule

// ===== rtl/trajectory_setpoint_generator.sv =====
// Trajectory setpoint generator: one guided time sample in, one position and
// velocity setpoint out. A load beat (tuser high) writes one waypoint. A guided
// sample runs through a sequencer around one shared 32x32 multiplier: for the
// sine and circle modes two phase products, two sine series of six products
// each and four scalings; for the zero modes straight to the output; for
// waypoint mode a 48-step bit-serial remainder, then a scan that reads each of
// the N waypoints in use from the store in turn, or straight to the output
// when the last waypoint time is zero. A sample without guided_active is
// dropped. s_tready is low while a sample is in work; a finished setpoint
// waits in the output register, and the next finished setpoint holds until
// that beat leaves.
// Depends on tsg_pkg, tsg_mul and tsg_wp_mem.
module trajectory_setpoint_generator
#(
    parameter int MAX_POINTS = 64,
    parameter int POS_WIDTH  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [119:0] s_tdata,  // time_us, guided_active, point_index, point_x,
                                   // point_y, point_time_us, zero pad
    input  logic        s_tuser,   // cmd
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((4*POS_WIDTH+7)/8)*8-1:0] m_tdata, // pos_x, pos_y, vel_x, vel_y, pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int OUT_DW = ((4*POS_WIDTH+7)/8)*8;
    localparam logic signed [32:0] OMAX = (33'sd1 <<< (POS_WIDTH-1)) - 33'sd1;
    localparam logic signed [32:0] OMIN = -OMAX - 33'sd1;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_PH0  = 5'd1;
    localparam logic [4:0] ST_PH1  = 5'd2;
    localparam logic [4:0] ST_PH2  = 5'd3;
    localparam logic [4:0] ST_SX   = 5'd4;
    localparam logic [4:0] ST_SSQ  = 5'd5;
    localparam logic [4:0] ST_SX2  = 5'd6;
    localparam logic [4:0] ST_SHM  = 5'd7;
    localparam logic [4:0] ST_SHT  = 5'd8;
    localparam logic [4:0] ST_SFM  = 5'd9;
    localparam logic [4:0] ST_SFIN = 5'd10;
    localparam logic [4:0] ST_KM   = 5'd11;
    localparam logic [4:0] ST_KR   = 5'd12;
    localparam logic [4:0] ST_WP0  = 5'd13;
    localparam logic [4:0] ST_WP1  = 5'd14;
    localparam logic [4:0] ST_DIV  = 5'd15;
    localparam logic [4:0] ST_SA   = 5'd16;
    localparam logic [4:0] ST_SB   = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;

    // configuration registers
    logic [2:0]  mode_reg;
    logic [14:0] amp_reg;
    logic [14:0] vamp_reg;
    logic [23:0] pstep_reg;
    logic [6:0]  pcnt_reg;

    // control
    logic [4:0]  state_reg, state_next;
    logic        started_reg;
    logic        sel_reg;
    logic [1:0]  hcnt_reg;
    logic [1:0]  j_reg;
    logic [5:0]  bcnt_reg;
    logic [CW-1:0] k_reg;
    logic        found_reg;
    logic        m_tvalid_reg;

    // datapath
    logic [47:0] start_reg;
    logic [47:0] elapsed_reg;
    logic [39:0] phase_reg;
    logic [16:0] x_reg;
    logic [16:0] x2_reg;
    logic [30:0] t_reg;
    logic [30:0] s_reg [2];
    logic [1:0]  neg_reg;
    logic [31:0] period_reg;
    logic [31:0] rem_reg;
    logic [31:0] prev_t_reg;
    logic signed [15:0] prev_x_reg;
    logic signed [15:0] prev_y_reg;
    logic signed [16:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [OUT_DW-1:0] m_tdata_reg;

    // input fields
    logic        in_cmd;
    logic [47:0] in_time;
    logic        in_guided;
    logic [5:0]  in_idx;
    logic signed [15:0] in_px;
    logic signed [15:0] in_py;
    logic [31:0] in_pt;
    logic        in_acc;

    assign in_cmd    = s_tuser;
    assign in_time   = s_tdata[47:0];
    assign in_guided = s_tdata[48];
    assign in_idx    = s_tdata[54:49];
    assign in_px     = s_tdata[70:55];
    assign in_py     = s_tdata[86:71];
    assign in_pt     = s_tdata[118:87];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // waypoint store
    logic          mem_we;
    logic [AW-1:0] mem_raddr;
    logic signed [15:0] mem_rx, mem_ry;
    logic [31:0]   mem_rt;
    logic [CW-1:0] n_pts;
    logic [AW-1:0] n_last;

    assign mem_we = in_acc && in_cmd && ({26'd0, in_idx} < 32'(MAX_POINTS));

    always_comb
    begin
        if (pcnt_reg < 7'd2)
            n_pts = CW'(2);
        else if (32'(pcnt_reg) > 32'(MAX_POINTS))
            n_pts = CW'(MAX_POINTS);
        else
            n_pts = CW'(pcnt_reg);
    end

    assign n_last    = AW'(n_pts - CW'(1));
    assign mem_raddr = (state_reg == ST_WP0) ? n_last : k_reg[AW-1:0];

    tsg_wp_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'({26'd0, in_idx})),
        .wx    (in_px),
        .wy    (in_py),
        .wt    (in_pt),
        .raddr (mem_raddr),
        .rx    (mem_rx),
        .ry    (mem_ry),
        .rt    (mem_rt)
    );

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        sidx;

    assign sidx = j_reg[0] ^ j_reg[1];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PH0:
            begin
                mul_a = {8'd0, elapsed_reg[23:0]};
                mul_b = {8'd0, pstep_reg};
            end
            ST_PH1:
            begin
                mul_a = {8'd0, elapsed_reg[47:24]};
                mul_b = {8'd0, pstep_reg};
            end
            ST_SSQ:
            begin
                mul_a = {15'd0, x_reg};
                mul_b = {15'd0, x_reg};
            end
            ST_SHM:
            begin
                mul_a = {15'd0, x2_reg};
                mul_b = {1'b0, t_reg};
            end
            ST_SFM:
            begin
                mul_a = {15'd0, x_reg};
                mul_b = {1'b0, t_reg};
            end
            ST_KM:
            begin
                mul_a = {17'd0, (j_reg[0] ? vamp_reg : amp_reg)};
                mul_b = {1'b0, s_reg[sidx]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tsg_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // combinational helpers
    logic [1:0]  sx_q;
    logic [15:0] sx_raw;
    logic [31:0] sfin_m;
    logic [30:0] horner_c;
    logic [63:0] kr_sum;
    logic [16:0] kr_mag;
    logic        kr_neg;
    logic signed [16:0] kr_val;
    logic [32:0] div_sh;
    logic [32:0] div_sub;
    logic        sb_hit;
    logic        fin_go;

    assign sx_q   = phase_reg[39:38] + {1'b0, sel_reg};
    assign sx_raw = phase_reg[37:22];
    assign sfin_m = mul_p[47:16];
    assign kr_sum = mul_p + tsg_pkg::HALF_Q30;
    assign kr_mag = kr_sum[46:30];
    assign kr_neg = neg_reg[sidx] ^ (j_reg == 2'd3);
    assign kr_val = kr_neg ? -$signed(kr_mag) : $signed(kr_mag);
    assign div_sh  = {rem_reg, elapsed_reg[47]};
    assign div_sub = div_sh - {1'b0, period_reg};
    assign sb_hit  = (k_reg != '0) && !found_reg && (rem_reg >= prev_t_reg)
                     && (rem_reg < mem_rt);
    assign fin_go  = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        case (hcnt_reg)
            2'd0:    horner_c = tsg_pkg::C7;
            2'd1:    horner_c = tsg_pkg::C5;
            2'd2:    horner_c = tsg_pkg::C3;
            default: horner_c = tsg_pkg::C1;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !in_cmd && in_guided)
                begin
                    if (mode_reg == tsg_pkg::MODE_XSINE || mode_reg == tsg_pkg::MODE_YSINE
                        || mode_reg == tsg_pkg::MODE_CIRCLE)
                        state_next = ST_PH0;
                    else if (mode_reg == tsg_pkg::MODE_WAYPT)
                        state_next = ST_WP0;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_PH0:  state_next = ST_PH1;
            ST_PH1:  state_next = ST_PH2;
            ST_PH2:  state_next = ST_SX;
            ST_SX:   state_next = ST_SSQ;
            ST_SSQ:  state_next = ST_SX2;
            ST_SX2:  state_next = ST_SHM;
            ST_SHM:  state_next = ST_SHT;
            ST_SHT:  state_next = (hcnt_reg == 2'd3) ? ST_SFM : ST_SHM;
            ST_SFM:  state_next = ST_SFIN;
            ST_SFIN: state_next = sel_reg ? ST_KM : ST_SX;
            ST_KM:   state_next = ST_KR;
            ST_KR:   state_next = (j_reg == 2'd3) ? ST_FIN : ST_KM;
            ST_WP0:  state_next = ST_WP1;
            ST_WP1:  state_next = (mem_rt == '0) ? ST_FIN : ST_DIV;
            ST_DIV:  state_next = (bcnt_reg == '0) ? ST_SA : ST_DIV;
            ST_SA:   state_next = ST_SB;
            ST_SB:   state_next = (k_reg + CW'(1) == n_pts) ? ST_FIN : ST_SA;
            ST_FIN:  state_next = (!m_tvalid_reg || m_tready) ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            started_reg  <= 1'b0;
            start_reg    <= '0;
            sel_reg      <= 1'b0;
            hcnt_reg     <= '0;
            j_reg        <= '0;
            bcnt_reg     <= '0;
            k_reg        <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && !in_cmd && in_guided && !started_reg)
                    begin
                        started_reg <= 1'b1;
                        start_reg   <= in_time;
                    end
                    sel_reg <= 1'b0;
                    j_reg   <= '0;
                end
                ST_SX2:  hcnt_reg <= '0;
                ST_SHT:  hcnt_reg <= hcnt_reg + 2'd1;
                ST_SFIN: sel_reg  <= 1'b1;
                ST_KR:   j_reg    <= j_reg + 2'd1;
                ST_WP1:  bcnt_reg <= 6'd47;
                ST_DIV:
                begin
                    bcnt_reg  <= bcnt_reg - 6'd1;
                    k_reg     <= '0;
                    found_reg <= 1'b0;
                end
                ST_SB:
                begin
                    k_reg <= k_reg + CW'(1);
                    if (sb_hit)
                        found_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    function automatic logic [POS_WIDTH-1:0] sat(input logic signed [16:0] v);
        logic signed [32:0] w;
        begin
            w = 33'(v);
            if (w > OMAX)
                w = OMAX;
            else if (w < OMIN)
                w = OMIN;
            sat = w[POS_WIDTH-1:0];
        end
    endfunction

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                elapsed_reg <= in_time - (started_reg ? start_reg : in_time);
                px_reg <= '0;
                py_reg <= '0;
                vx_reg <= '0;
                vy_reg <= '0;
            end
            ST_PH1: phase_reg <= mul_p[39:0];
            ST_PH2: phase_reg <= phase_reg + {mul_p[15:0], 24'd0};
            ST_SX:
            begin
                x_reg <= sx_q[0] ? (17'h10000 - {1'b0, sx_raw}) : {1'b0, sx_raw};
                neg_reg[sel_reg] <= sx_q[1];
            end
            ST_SX2:
            begin
                x2_reg <= mul_p[32:16];
                t_reg  <= tsg_pkg::C9;
            end
            ST_SHT:  t_reg <= horner_c - mul_p[46:16];
            ST_SFIN: s_reg[sel_reg] <= (sfin_m > tsg_pkg::ONE_Q30) ?
                                       tsg_pkg::ONE_Q30[30:0] : sfin_m[30:0];
            ST_KR:
            begin
                case (j_reg)
                    2'd0:
                        if (mode_reg == tsg_pkg::MODE_YSINE)
                            py_reg <= kr_val;
                        else
                            px_reg <= kr_val;
                    2'd1:
                        if (mode_reg == tsg_pkg::MODE_YSINE)
                            vy_reg <= kr_val;
                        else
                            vx_reg <= kr_val;
                    2'd2:
                        if (mode_reg == tsg_pkg::MODE_CIRCLE)
                            py_reg <= kr_val;
                    default:
                        if (mode_reg == tsg_pkg::MODE_CIRCLE)
                            vy_reg <= kr_val;
                endcase
            end
            ST_WP1:
            begin
                period_reg <= mem_rt;
                rem_reg    <= '0;
            end
            ST_DIV:
            begin
                // one quotient bit per cycle; keep only the remainder
                rem_reg     <= div_sub[32] ? div_sh[31:0] : div_sub[31:0];
                elapsed_reg <= {elapsed_reg[46:0], 1'b0};
            end
            ST_SB:
            begin
                if (sb_hit)
                begin
                    px_reg <= 17'(prev_x_reg);
                    py_reg <= 17'(prev_y_reg);
                end
                prev_t_reg <= mem_rt;
                prev_x_reg <= mem_rx;
                prev_y_reg <= mem_ry;
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                    m_tdata_reg <= OUT_DW'({sat(vy_reg), sat(vx_reg), sat(py_reg), sat(px_reg)});
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tsg_pkg::RST_MODE;
            amp_reg   <= tsg_pkg::RST_AMP;
            vamp_reg  <= tsg_pkg::RST_VAMP;
            pstep_reg <= tsg_pkg::RST_PSTEP;
            pcnt_reg  <= tsg_pkg::RST_PCNT;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                tsg_pkg::REG_MODE:  mode_reg  <= pwdata[2:0];
                tsg_pkg::REG_AMP:   amp_reg   <= pwdata[14:0];
                tsg_pkg::REG_VAMP:  vamp_reg  <= pwdata[14:0];
                tsg_pkg::REG_PSTEP: pstep_reg <= pwdata[23:0];
                tsg_pkg::REG_PCNT:  pcnt_reg  <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            tsg_pkg::REG_MODE:  prdata = {29'd0, mode_reg};
            tsg_pkg::REG_AMP:   prdata = {17'd0, amp_reg};
            tsg_pkg::REG_VAMP:  prdata = {17'd0, vamp_reg};
            tsg_pkg::REG_PSTEP: prdata = {8'd0, pstep_reg};
            tsg_pkg::REG_PCNT:  prdata = {25'd0, pcnt_reg};
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/tsg_checker.sv =====
// Port-level checks for the trajectory setpoint generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tsg_checker
#(
    parameter int POS_WIDTH = 16
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [119:0] s_tdata,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [((4*POS_WIDTH+7)/8)*8-1:0] m_tdata
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a guided sample beat makes the block busy
    `ASSERT_NEXT(a_busy_after_sample, s_tvalid && s_tready && !s_tuser && s_tdata[48], !s_tready)
    // a load beat never raises a result
    `ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && s_tuser && !m_tvalid, !m_tvalid)
    // an unguided sample beat leaves the block ready
    `ASSERT_NEXT(a_drop_unguided, s_tvalid && s_tready && !s_tuser && !s_tdata[48], s_tready)

endmodule

bind trajectory_setpoint_generator tsg_checker #(.POS_WIDTH(POS_WIDTH)) u_tsg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/trajectory_setpoint_generator_tb.sv =====
// Self-checking bench for the trajectory setpoint generator: stream beats in,
// setpoints out, APB register writes between phases. Depends on tsg_pkg and the RTL.
module trajectory_setpoint_generator_tb;

    localparam int NPTS = 64;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;  // time_us, guided_active, point_index, point_x,
                                 // point_y, point_time_us, zero pad
    logic         s_tuser = 1'b0; // cmd
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;       // pos_x, pos_y, vel_x, vel_y
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    trajectory_setpoint_generator uut (.*);

    always #10 clk = ~clk;

    // predictor copy of registers and state
    logic [2:0]  cur_mode;
    logic [14:0] cur_amp, cur_vamp;
    logic [23:0] cur_pstep;
    logic [6:0]  cur_pcnt;
    logic [47:0] origin_us;
    logic        origin_valid;
    logic signed [15:0] wp_x [NPTS];
    logic signed [15:0] wp_y [NPTS];
    logic [31:0] wp_t [NPTS];

    logic [63:0] setpoint_q [$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    string field_name [4] = '{"pos_x", "pos_y", "vel_x", "vel_y"};
    logic [6:0] cur_pcnt_set [5] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd50};

    initial
    begin
        #100000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (setpoint_q.size() == 0)
            begin
                $error("setpoint with none expected: %h", m_tdata);
                errors++;
            end
            else
            begin
                logic [63:0] exp_sp;
                exp_sp = setpoint_q.pop_front();
                for (int f = 0; f < 4; f++)
                    if (m_tdata[16*f +: 16] !== exp_sp[16*f +: 16])
                    begin
                        $error("%s expected %0d actual %0d", field_name[f],
                               $signed(exp_sp[16*f +: 16]), $signed(m_tdata[16*f +: 16]));
                        errors++;
                    end
            end
        end
    end

    function automatic logic signed [63:0] wave(input logic [63:0] k, input logic [39:0] ph);
        logic [63:0] x, x2, t, m, v;
        x = 64'(ph[37:22]);
        if (ph[38])
            x = 64'd65536 - x;
        x2 = (x * x) >> 16;
        t = 64'(tsg_pkg::C9);
        t = tsg_pkg::C7 - ((x2 * t) >> 16);
        t = tsg_pkg::C5 - ((x2 * t) >> 16);
        t = tsg_pkg::C3 - ((x2 * t) >> 16);
        t = tsg_pkg::C1 - ((x2 * t) >> 16);
        m = (x * t) >> 16;
        if (m > tsg_pkg::ONE_Q30)
            m = 64'(tsg_pkg::ONE_Q30);
        v = (k * m + tsg_pkg::HALF_Q30) >> 30;
        return ph[39] ? -$signed(v) : $signed(v);
    endfunction

    function automatic logic [15:0] clamp16(input logic signed [63:0] v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // update the predictor for one accepted beat; queue the setpoint if it causes one
    task automatic predict_setpoint(input logic cmd, input logic [47:0] t_us, input logic ga,
                                    input logic [5:0] idx, input logic [15:0] x,
                                    input logic [15:0] y, input logic [31:0] pt);
        logic [47:0] elapsed;
        logic [39:0] ph, cph;
        logic signed [63:0] px, py, vx, vy;
        logic [63:0] dt, period;
        int n;
        px = '0; py = '0; vx = '0; vy = '0;
        if (cmd)
        begin
            wp_x[idx] = x;
            wp_y[idx] = y;
            wp_t[idx] = pt;
            return;
        end
        if (!ga)
            return;
        if (!origin_valid)
        begin
            origin_us = t_us;
            origin_valid = 1'b1;
        end
        elapsed = t_us - origin_us;
        ph = 40'(64'(elapsed) * 64'(cur_pstep));
        cph = ph + 40'h40_0000_0000;
        case (cur_mode)
            tsg_pkg::MODE_XSINE:
            begin
                px = wave(64'(cur_amp), ph);
                vx = wave(64'(cur_vamp), cph);
            end
            tsg_pkg::MODE_YSINE:
            begin
                py = wave(64'(cur_amp), ph);
                vy = wave(64'(cur_vamp), cph);
            end
            tsg_pkg::MODE_CIRCLE:
            begin
                px = wave(64'(cur_amp), ph);
                py = wave(64'(cur_amp), cph);
                vx = wave(64'(cur_vamp), cph);
                vy = -wave(64'(cur_vamp), ph);
            end
            tsg_pkg::MODE_WAYPT:
            begin
                n = (cur_pcnt < 2) ? 2 : (cur_pcnt > NPTS) ? NPTS : int'(cur_pcnt);
                period = 64'(wp_t[n-1]);
                if (period != 0)
                begin
                    dt = 64'(elapsed) % period;
                    for (int i = 0; i + 1 < n; i++)
                        if (dt >= wp_t[i] && dt < wp_t[i+1])
                        begin
                            px = 64'(wp_x[i]);
                            py = 64'(wp_y[i]);
                            break;
                        end
                end
            end
            default: ;
        endcase
        setpoint_q.push_back({clamp16(vy), clamp16(vx), clamp16(py), clamp16(px)});
    endtask

    // valid stays high after acceptance; settle lowers it
    task automatic send_beat(input logic cmd, input logic [47:0] t_us, input logic ga,
                             input logic [5:0] idx, input logic [15:0] x,
                             input logic [15:0] y, input logic [31:0] pt);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, pt, y, x, idx, ga, t_us};
        do
            @(posedge clk);
        while (!s_tready);
        predict_setpoint(cmd, t_us, ga, idx, x, y, pt);
    endtask

    task automatic sample(input logic [47:0] t_us, input logic ga = 1'b1);
        send_beat(1'b0, t_us, ga, 6'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic load_point(input logic [5:0] idx, input logic [15:0] x,
                              input logic [15:0] y, input logic [31:0] pt);
        send_beat(1'b1, 48'({$urandom, $urandom}), 1'($urandom), idx, x, y, pt);
    endtask

    // drop valid, wait for every setpoint, then let a waypoint pass finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            tsg_pkg::REG_MODE:  cur_mode  = val[2:0];
            tsg_pkg::REG_AMP:   cur_amp   = val[14:0];
            tsg_pkg::REG_VAMP:  cur_vamp  = val[14:0];
            tsg_pkg::REG_PSTEP: cur_pstep = val[23:0];
            tsg_pkg::REG_PCNT:  cur_pcnt  = val[6:0];
            default: ;
        endcase
    endtask

    task automatic load_ordered_table();
        logic [31:0] acc;
        acc = $urandom_range(0, 3);
        for (int i = 0; i < NPTS; i++)
        begin
            load_point(6'(i), 16'($urandom), 16'($urandom), acc);
            acc += $urandom_range(1, 3000);
        end
    endtask

    task automatic test_reset_state();
        sample(48'({$urandom, $urandom}), 1'b0);  // dropped, start not latched
        sample(48'hffff_ffff_ffff);               // latches start, mode 4 gives zeros
        sample(48'h0);                            // elapsed wraps to 1
        sample(48'h7fff_0000_0001);
    endtask

    task automatic test_sine_modes();
        settle();
        write_reg(tsg_pkg::REG_AMP, 32'h7fff);
        write_reg(tsg_pkg::REG_VAMP, 32'h7fff);
        write_reg(tsg_pkg::REG_PSTEP, 32'hff_ffff);
        for (int m = 0; m < 3; m++)
        begin
            settle();
            write_reg(tsg_pkg::REG_MODE, m);
            for (int i = 0; i < 3; i++)
                sample(origin_us + 48'($urandom_range(0, 5000)));
        end
        settle();
        write_reg(tsg_pkg::REG_AMP, 0);
        write_reg(tsg_pkg::REG_VAMP, 0);
        sample(origin_us + 48'd77);
        settle();
        write_reg(tsg_pkg::REG_PSTEP, 0);
        write_reg(tsg_pkg::REG_AMP, 32'hffff_ffff); // upper bits drop to the field width
        sample(48'h1234_5678_9abc);
    endtask

    task automatic test_waypoints();
        load_point(6'd63, 16'h8000, 16'h7fff, 32'hffff_ffff);
        load_ordered_table();
        settle();
        write_reg(tsg_pkg::REG_MODE, 32'(tsg_pkg::MODE_WAYPT));
        foreach (cur_pcnt_set[i])
        begin
            settle();
            write_reg(tsg_pkg::REG_PCNT, 32'(cur_pcnt_set[i]));
            sample(origin_us + 48'($urandom_range(0, 200000)));
            sample(48'({$urandom, $urandom}));
        end
        // zero period gives zeros
        load_point(6'd1, 16'h7fff, 16'h8000, 32'd0);
        settle();
        write_reg(tsg_pkg::REG_PCNT, 2);
        sample(origin_us + 48'd5);
        // descending times leave no matching interval
        load_point(6'd1, 16'h1111, 16'h2222, 32'd10);
        load_point(6'd0, 16'h3333, 16'h4444, 32'd20);
        sample(origin_us + 48'd3);
    endtask

    task automatic test_random(input int s_idle, input int r_idle, input int count);
        logic [47:0] t;
        int pick;
        settle();
        send_idle = s_idle;
        recv_idle = r_idle;
        write_reg(tsg_pkg::REG_MODE, $urandom_range(0, 7));
        write_reg(tsg_pkg::REG_AMP, ($urandom_range(3) == 0) ? 32'h7fff : $urandom);
        write_reg(tsg_pkg::REG_VAMP, ($urandom_range(3) == 0) ? 32'h7fff : $urandom);
        write_reg(tsg_pkg::REG_PSTEP, $urandom);
        write_reg(tsg_pkg::REG_PCNT, $urandom_range(0, 127));
        load_ordered_table();
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (i % 50 == 25)
            begin
                settle();
                write_reg(tsg_pkg::REG_MODE, ($urandom_range(1) == 0) ?
                          32'(tsg_pkg::MODE_WAYPT) : $urandom_range(0, 7));
                write_reg(tsg_pkg::REG_PCNT, $urandom_range(0, 127));
            end
            if (pick < 12)
                load_point(6'($urandom), 16'($urandom), 16'($urandom),
                           ($urandom_range(1)) ? $urandom_range(0, 200000) : $urandom);
            else if (pick < 20)
                sample(48'({$urandom, $urandom}), 1'b0);
            else
            begin
                t = (pick < 35) ? 48'({$urandom, $urandom})
                                : origin_us + 48'($urandom_range(0, 400000));
                sample(t);
            end
        end
    endtask

    initial
    begin
        cur_mode = tsg_pkg::RST_MODE;
        cur_amp = tsg_pkg::RST_AMP;
        cur_vamp = tsg_pkg::RST_VAMP;
        cur_pstep = tsg_pkg::RST_PSTEP;
        cur_pcnt = tsg_pkg::RST_PCNT;
        origin_us = '0;
        origin_valid = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_sine_modes();
        test_waypoints();
        test_random(29, 58, 220);
        test_random(58, 29, 220);
        test_random(0, 0, 220);
        settle();
        if (setpoint_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
